[src/acfl_pkg.sv]
// Shared constants and types for the associative cache with FIFO/LRU replacement.
package acfl_pkg;

    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'd1;

    // Replacement policy codes
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    // Request type codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

    // Lookup token that sweeps along the slot row
    typedef struct packed {
        logic             act;
        logic             found;
        logic [VAL_W-1:0] value;
    } t_look_tok;

endpackage

[src/acfl_slot_cell.sv]
// One cache slot: stored key/value plus one stage of the lookup sweep.
module acfl_slot_cell #(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [acfl_pkg::KEY_W-1:0]    i_key,
    input  logic [acfl_pkg::VAL_W-1:0]    i_wval,
    input  logic [$clog2(ENTRIES+1)-1:0]  i_filled,
    input  acfl_pkg::t_look_tok           i_tok,
    input  logic [$clog2(ENTRIES)-1:0]    i_idx,
    output acfl_pkg::t_look_tok           o_tok,
    output logic [$clog2(ENTRIES)-1:0]    o_idx
);
    localparam int SZW = $clog2(ENTRIES + 1);
    localparam int IW  = $clog2(ENTRIES);

    logic [acfl_pkg::KEY_W-1:0] r_key;
    logic [acfl_pkg::VAL_W-1:0] r_value;
    logic                       r_act;
    logic                       r_found;
    logic [acfl_pkg::VAL_W-1:0] r_tval;
    logic [IW-1:0]              r_idx;
    logic                       hit_here;

    // only filled slots take part, and only the first match counts
    assign hit_here = !i_tok.found && (SZW'(IDX) < i_filled) && (r_key == i_key);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key   <= i_key;
            r_value <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= i_tok.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.act) begin
            r_found <= i_tok.found | hit_here;
            r_tval  <= hit_here ? r_value : i_tok.value;
            r_idx   <= hit_here ? IW'(IDX) : i_idx;
        end
    end

    assign o_tok.act   = r_act;
    assign o_tok.found = r_found;
    assign o_tok.value = r_tval;
    assign o_idx       = r_idx;

endmodule

[src/acfl_rec_cell.sv]
// One position of the recency row; a move-to-front token ripples through it.
module acfl_rec_cell #(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_act,
    input  logic [$clog2(ENTRIES)-1:0]  i_slot,
    input  logic [$clog2(ENTRIES)-1:0]  i_carry,
    output logic                        o_act,
    output logic [$clog2(ENTRIES)-1:0]  o_slot,
    output logic [$clog2(ENTRIES)-1:0]  o_carry,
    output logic [$clog2(ENTRIES)-1:0]  o_order
);
    localparam int IW = $clog2(ENTRIES);

    logic [IW-1:0] r_order;
    logic          r_act;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_carry;

    // take the carried entry; pass the old one on unless it was the moved slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= IW'(IDX);
            r_act   <= 1'b0;
        end else begin
            r_act <= i_act && (r_order != i_slot);
            if (i_act) begin
                r_order <= i_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_act) begin
            r_slot  <= i_slot;
            r_carry <= r_order;
        end
    end

    assign o_act   = r_act;
    assign o_slot  = r_slot;
    assign o_carry = r_carry;
    assign o_order = r_order;

endmodule

[src/assoc_cache_fifo_lru_unit.sv]
// Fully associative key/value cache, FIFO or LRU replacement, built as rows of cells.
// A lookup result strobes after the lookup token walks the slot row one cell per cycle;
// an insert answers from the decode state, an LRU replacement after the victim read
// and write states. An LRU update keeps the block busy while the move-to-front token
// ripples down the recency row. One request at a time.
// Results cannot be held off. Reset (sync, active low) empties cache, zeroes counters.
module assoc_cache_fifo_lru_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [acfl_pkg::KEY_W-1:0]        i_key,
    input  logic [acfl_pkg::VAL_W-1:0]        i_write_value,
    input  logic                              i_cfg_we,
    input  logic [acfl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [acfl_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic [acfl_pkg::VAL_W-1:0]        o_read_value,
    output logic [acfl_pkg::CNT_W-1:0]        o_hit_count,
    output logic [acfl_pkg::CNT_W-1:0]        o_lookup_count
);
    localparam int SZW = $clog2(ENTRIES + 1);
    localparam int IW  = $clog2(ENTRIES);

    // control states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;  // decode request
    localparam logic [2:0] ST_LOOK = 3'd2;  // lookup token in flight
    localparam logic [2:0] ST_VICT = 3'd3;  // read LRU victim
    localparam logic [2:0] ST_REPL = 3'd4;  // write LRU victim
    localparam logic [2:0] ST_REC  = 3'd5;  // recency token in flight

    logic [2:0]                  r_state, n_state;
    logic                        r_policy;
    logic [acfl_pkg::CFG_W-1:0]  r_entries;
    logic                        r_req;
    logic [acfl_pkg::KEY_W-1:0]  r_key;
    logic [acfl_pkg::VAL_W-1:0]  r_wval;
    logic [SZW-1:0]              r_filled;
    logic [IW-1:0]               r_fifo_ptr;
    logic [IW-1:0]               r_victim;
    logic [acfl_pkg::CNT_W-1:0]  r_hits;
    logic [acfl_pkg::CNT_W-1:0]  r_lookups;
    acfl_pkg::t_look_tok         r_ltok;
    logic                        r_rtok_act;
    logic [IW-1:0]               r_rtok_slot;

    logic                        accept;
    logic [SZW-1:0]              size;
    logic [IW-1:0]               size_m1;
    logic                        do_fill;
    logic [IW-1:0]               fifo_victim;
    logic [SZW-1:0]              fifo_vp1;
    logic [IW-1:0]               fifo_next;
    logic                        wr_en;
    logic [IW-1:0]               wr_slot;

    acfl_pkg::t_look_tok         look_tok [ENTRIES];
    logic [IW-1:0]               look_idx [ENTRIES];
    logic                        rec_act  [ENTRIES];
    logic [IW-1:0]               rec_slot [ENTRIES];
    logic [IW-1:0]               rec_carry[ENTRIES];
    logic [IW-1:0]               rec_order[ENTRIES];
    logic [ENTRIES-1:0]          rec_act_vec;
    logic                        rec_busy;
    acfl_pkg::t_look_tok         look_last;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // effective slot count, clamped to 1..ENTRIES
    always_comb begin
        if (r_entries == '0) begin
            size = SZW'(1);
        end else if (32'(r_entries) > ENTRIES) begin
            size = SZW'(ENTRIES);
        end else begin
            size = SZW'(r_entries);
        end
    end
    assign size_m1 = IW'(size - SZW'(1));

    assign do_fill = (r_filled < size);

    // FIFO victim: pointer past the slot count falls back to slot 0
    assign fifo_victim = (SZW'(r_fifo_ptr) < size) ? r_fifo_ptr : '0;
    assign fifo_vp1    = SZW'(fifo_victim) + SZW'(1);
    assign fifo_next   = (fifo_vp1 == size) ? '0 : IW'(fifo_vp1);

    // slot write port, decoded per cell
    always_comb begin
        wr_en   = 1'b0;
        wr_slot = r_victim;
        case (r_state)
            ST_EXEC: begin
                if (r_req == acfl_pkg::REQ_INSERT) begin
                    if (do_fill) begin
                        wr_en   = 1'b1;
                        wr_slot = IW'(r_filled);
                    end else if (r_policy == acfl_pkg::POL_FIFO) begin
                        wr_en   = 1'b1;
                        wr_slot = fifo_victim;
                    end
                end
            end
            ST_REPL: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // slot row and recency row
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cells
            acfl_slot_cell #(
                .ENTRIES (ENTRIES),
                .IDX     (g)
            ) u_slot (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_we     (wr_en && (wr_slot == IW'(g))),
                .i_key    (r_key),
                .i_wval   (r_wval),
                .i_filled (r_filled),
                .i_tok    ((g == 0) ? r_ltok : look_tok[(g == 0) ? 0 : g - 1]),
                .i_idx    ((g == 0) ? IW'(0) : look_idx[(g == 0) ? 0 : g - 1]),
                .o_tok    (look_tok[g]),
                .o_idx    (look_idx[g])
            );

            acfl_rec_cell #(
                .ENTRIES (ENTRIES),
                .IDX     (g)
            ) u_rec (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_act   ((g == 0) ? r_rtok_act : rec_act[(g == 0) ? 0 : g - 1]),
                .i_slot  ((g == 0) ? r_rtok_slot : rec_slot[(g == 0) ? 0 : g - 1]),
                .i_carry ((g == 0) ? r_rtok_slot : rec_carry[(g == 0) ? 0 : g - 1]),
                .o_act   (rec_act[g]),
                .o_slot  (rec_slot[g]),
                .o_carry (rec_carry[g]),
                .o_order (rec_order[g])
            );

            assign rec_act_vec[g] = rec_act[g];
        end
    endgenerate

    assign rec_busy  = r_rtok_act || (|rec_act_vec);
    assign look_last = look_tok[ENTRIES-1];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_req == acfl_pkg::REQ_LOOKUP) begin
                    n_state = ST_LOOK;
                end else if (do_fill) begin
                    n_state = (r_policy == acfl_pkg::POL_LRU) ? ST_REC : ST_IDLE;
                end else if (r_policy == acfl_pkg::POL_FIFO) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_VICT;
                end
            end
            ST_LOOK: begin
                if (look_last.act) begin
                    n_state = (look_last.found && r_policy == acfl_pkg::POL_LRU)
                              ? ST_REC : ST_IDLE;
                end
            end
            ST_VICT: begin
                n_state = ST_REPL;
            end
            ST_REPL: begin
                n_state = ST_REC;
            end
            ST_REC: begin
                if (!rec_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        // the lookup token always enters the row empty-handed
        r_ltok.found <= 1'b0;
        r_ltok.value <= '0;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_policy    <= acfl_pkg::POL_FIFO;
            r_entries   <= acfl_pkg::ENTRIES_RESET;
            r_filled    <= '0;
            r_fifo_ptr  <= '0;
            r_hits      <= '0;
            r_lookups   <= '0;
            r_ltok.act  <= 1'b0;
            r_rtok_act  <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_state    <= n_state;
            o_valid    <= 1'b0;
            r_ltok.act <= 1'b0;
            r_rtok_act <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    acfl_pkg::REG_POLICY:  r_policy  <= i_cfg_data[0];
                    acfl_pkg::REG_ENTRIES: r_entries <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_EXEC: begin
                    if (r_req == acfl_pkg::REQ_LOOKUP) begin
                        r_ltok.act <= 1'b1;
                    end else begin
                        if (do_fill) begin
                            r_filled   <= r_filled + SZW'(1);
                            r_rtok_act <= (r_policy == acfl_pkg::POL_LRU);
                            o_valid    <= 1'b1;
                        end else if (r_policy == acfl_pkg::POL_FIFO) begin
                            r_fifo_ptr <= fifo_next;
                            o_valid    <= 1'b1;
                        end
                    end
                end
                ST_LOOK: begin
                    if (look_last.act) begin
                        r_lookups  <= r_lookups + acfl_pkg::CNT_W'(1);
                        r_hits     <= r_hits + {{(acfl_pkg::CNT_W-1){1'b0}}, look_last.found};
                        r_rtok_act <= look_last.found && (r_policy == acfl_pkg::POL_LRU);
                        o_valid    <= 1'b1;
                    end
                end
                ST_REPL: begin
                    r_rtok_act <= 1'b1;
                    o_valid    <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_key  <= i_key;
            r_wval <= i_write_value;
        end
        case (r_state)
            ST_EXEC: begin
                // insert answers: no hit, zero value, totals unchanged
                r_rtok_slot    <= IW'(r_filled);
                o_hit          <= 1'b0;
                o_read_value   <= '0;
                o_hit_count    <= r_hits;
                o_lookup_count <= r_lookups;
            end
            ST_LOOK: begin
                r_rtok_slot    <= look_idx[ENTRIES-1];
                o_hit          <= look_last.found;
                o_read_value   <= look_last.value;
                o_hit_count    <= r_hits + {{(acfl_pkg::CNT_W-1){1'b0}}, look_last.found};
                o_lookup_count <= r_lookups + acfl_pkg::CNT_W'(1);
            end
            ST_VICT: begin
                // least recently used slot sits at the last active recency position
                r_victim <= rec_order[size_m1];
            end
            ST_REPL: begin
                r_rtok_slot    <= r_victim;
                o_hit          <= 1'b0;
                o_read_value   <= '0;
                o_hit_count    <= r_hits;
                o_lookup_count <= r_lookups;
            end
            default: ;
        endcase
    end

    // result strobes are never back to back
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    // a taken request always makes the block busy next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request taken but block not busy");

    // fill count never passes capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= SZW'(ENTRIES))
        else $error("fill count beyond capacity");

    // lookup sweep and recency walk never overlap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ltok.act && rec_busy))
        else $error("lookup token and recency token both active");

    // recency walk only runs in its own state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|rec_act_vec) |-> (r_state == ST_REC))
        else $error("recency token outside walk state");

endmodule
